@@ rtl/ntf_pkg.sv @@
// Shared types and constants for the nearest target follow controller.
`default_nettype none

package ntf_pkg;

    // Field widths
    localparam int ClassW = 8;
    localparam int RangeW = 15;
    localparam int CmdW   = 16;
    localparam int AlphaW = 17;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 17;

    // Register indexes
    localparam logic [CfgIdxW-1:0] REG_TARGET_CLASS = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_MAX_RANGE    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_MIN_RANGE    = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_ALPHA        = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_FOLLOW_SPEED = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_HEADING_GAIN = 3'd5;

    // Register reset values
    localparam logic [ClassW-1:0]      RST_TARGET_CLASS = 8'd0;
    localparam logic [RangeW-1:0]      RST_MAX_RANGE    = 15'd1280;
    localparam logic [RangeW-1:0]      RST_MIN_RANGE    = 15'd256;
    localparam logic [AlphaW-1:0]      RST_ALPHA        = 17'd32768;
    localparam logic signed [CmdW-1:0] RST_FOLLOW_SPEED = 16'sd256;
    localparam logic signed [CmdW-1:0] RST_HEADING_GAIN = 16'sd256;

    // 100 m start value of the running minimum, 1 m snap band, unity weight
    localparam logic [RangeW-1:0]  SENTINEL_Z     = 15'd25600;
    localparam logic signed [15:0] SNAP_THRESHOLD = 16'sd256;
    localparam logic [AlphaW-1:0]  ALPHA_ONE      = 17'd65536;

    typedef struct packed {
        logic [ClassW-1:0]      target_class;
        logic [RangeW-1:0]      max_range;
        logic [RangeW-1:0]      min_range;
        logic [AlphaW-1:0]      alpha;
        logic signed [CmdW-1:0] follow_speed;
        logic signed [CmdW-1:0] heading_gain;
    } t_cfg;

    // Summary of one finished frame, handed from tracker to filter
    typedef struct packed {
        logic [RangeW-1:0]      near_z;
        logic signed [CmdW-1:0] near_x;
        logic signed [CmdW-1:0] vel_in;
        logic signed [CmdW-1:0] ang_in;
    } t_frame;

endpackage

`default_nettype wire

@@ rtl/nearest_target_follow_control.sv @@
// Nearest target follow controller, top level.
//
// Input channel (i_in_valid / o_in_ready) carries one detection per item;
// an item with i_last_in_frame high closes the frame. Each detection of the
// configured class nearer than the current best replaces it; the best starts
// each frame at 100 m. Only the closing item produces a result on the output
// channel (o_out_valid / i_out_ready): drive commands, lock flag, smoothed
// range and the chosen detection. Other items produce nothing.
// Throughput: one item per cycle unless the output stalls; frames may close
// on consecutive cycles. The summary register is loaded first when a closing
// item is accepted, then the lock/filter/command logic feeds the result
// register, which drives o_out_valid. A stall on the output holds the
// result; the summary register then fills and o_in_ready drops only when
// both are full. Configuration is a plain write port (i_cfg_we, i_cfg_idx,
// i_cfg_data); the user must see that it is written only while the block
// is idle; the block itself does not enforce this. Synchronous active-low
// reset restores the register defaults, clears the smoothed range to zero,
// sets the search back to the sentinel and empties both registers.
`default_nettype none

module nearest_target_follow_control (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [ntf_pkg::CfgIdxW-1:0]        i_cfg_idx,
    input  wire logic [ntf_pkg::CfgDataW-1:0]       i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic                               i_detection_valid,
    input  wire logic [ntf_pkg::ClassW-1:0]         i_class_id,
    input  wire logic signed [ntf_pkg::CmdW-1:0]    i_target_x,
    input  wire logic [ntf_pkg::RangeW-1:0]         i_target_z,
    input  wire logic                               i_last_in_frame,
    input  wire logic signed [ntf_pkg::CmdW-1:0]    i_velocity_in,
    input  wire logic signed [ntf_pkg::CmdW-1:0]    i_angular_in,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed [ntf_pkg::CmdW-1:0]         o_velocity_out,
    output logic signed [ntf_pkg::CmdW-1:0]         o_angular_out,
    output logic                                    o_locked,
    output logic [ntf_pkg::RangeW-1:0]              o_filtered_range,
    output logic signed [ntf_pkg::CmdW-1:0]         o_chosen_x,
    output logic [ntf_pkg::RangeW-1:0]              o_chosen_z
);

    ntf_pkg::t_cfg   cfg;
    ntf_pkg::t_frame frm;
    logic            frm_valid;
    logic            take;

    // Register bank
    ntf_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Nearest search
    ntf_track u_track (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_target_class    (cfg.target_class),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_detection_valid (i_detection_valid),
        .i_class_id        (i_class_id),
        .i_target_x        (i_target_x),
        .i_target_z        (i_target_z),
        .i_last_in_frame   (i_last_in_frame),
        .i_velocity_in     (i_velocity_in),
        .i_angular_in      (i_angular_in),
        .i_take            (take),
        .o_frm_valid       (frm_valid),
        .o_frm             (frm)
    );

    // Lock, smoothing and commands
    ntf_filter u_filter (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_frm_valid      (frm_valid),
        .i_frm            (frm),
        .o_take           (take),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_velocity_out   (o_velocity_out),
        .o_angular_out    (o_angular_out),
        .o_locked         (o_locked),
        .o_filtered_range (o_filtered_range),
        .o_chosen_x       (o_chosen_x),
        .o_chosen_z       (o_chosen_z)
    );

endmodule

`default_nettype wire

@@ rtl/ntf_cfg.sv @@
// Configuration register bank.
`default_nettype none

module ntf_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [ntf_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  wire logic [ntf_pkg::CfgDataW-1:0]  i_cfg_data,
    output ntf_pkg::t_cfg                      o_cfg
);

    ntf_pkg::t_cfg r_cfg;
    ntf_pkg::t_cfg n_cfg;

    // Write decode; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ntf_pkg::REG_TARGET_CLASS: n_cfg.target_class = i_cfg_data[7:0];
                ntf_pkg::REG_MAX_RANGE:    n_cfg.max_range    = i_cfg_data[14:0];
                ntf_pkg::REG_MIN_RANGE:    n_cfg.min_range    = i_cfg_data[14:0];
                ntf_pkg::REG_ALPHA:        n_cfg.alpha        = i_cfg_data[16:0];
                ntf_pkg::REG_FOLLOW_SPEED: n_cfg.follow_speed = i_cfg_data[15:0];
                ntf_pkg::REG_HEADING_GAIN: n_cfg.heading_gain = i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_class <= ntf_pkg::RST_TARGET_CLASS;
            r_cfg.max_range    <= ntf_pkg::RST_MAX_RANGE;
            r_cfg.min_range    <= ntf_pkg::RST_MIN_RANGE;
            r_cfg.alpha        <= ntf_pkg::RST_ALPHA;
            r_cfg.follow_speed <= ntf_pkg::RST_FOLLOW_SPEED;
            r_cfg.heading_gain <= ntf_pkg::RST_HEADING_GAIN;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/ntf_track.sv @@
// Running nearest-detection search and frame summary register.
`default_nettype none

module ntf_track (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [ntf_pkg::ClassW-1:0]         i_target_class,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic                               i_detection_valid,
    input  wire logic [ntf_pkg::ClassW-1:0]         i_class_id,
    input  wire logic signed [ntf_pkg::CmdW-1:0]    i_target_x,
    input  wire logic [ntf_pkg::RangeW-1:0]         i_target_z,
    input  wire logic                               i_last_in_frame,
    input  wire logic signed [ntf_pkg::CmdW-1:0]    i_velocity_in,
    input  wire logic signed [ntf_pkg::CmdW-1:0]    i_angular_in,
    input  wire logic                               i_take,
    output logic                                    o_frm_valid,
    output ntf_pkg::t_frame                         o_frm
);

    logic [ntf_pkg::RangeW-1:0]      r_near_z;
    logic signed [ntf_pkg::CmdW-1:0] r_near_x;
    logic                            r_frm_valid;
    ntf_pkg::t_frame                 r_frm;

    logic                            accept;
    logic                            hit;
    logic [ntf_pkg::RangeW-1:0]      cur_z;
    logic signed [ntf_pkg::CmdW-1:0] cur_x;

    // Frame register frees up in the cycle its summary moves on
    assign o_in_ready = !r_frm_valid || i_take;
    assign accept     = i_in_valid && o_in_ready;

    // Detection on this item counts before the frame closes
    assign hit   = i_detection_valid && (i_class_id == i_target_class) &&
                   (i_target_z < r_near_z);
    assign cur_z = hit ? i_target_z : r_near_z;
    assign cur_x = hit ? i_target_x : r_near_x;

    // Running minimum, back to the sentinel once a frame closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_z <= ntf_pkg::SENTINEL_Z;
            r_near_x <= '0;
        end else if (accept) begin
            if (i_last_in_frame) begin
                r_near_z <= ntf_pkg::SENTINEL_Z;
                r_near_x <= '0;
            end else begin
                r_near_z <= cur_z;
                r_near_x <= cur_x;
            end
        end
    end

    // Frame summary valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frm_valid <= 1'b0;
        end else if (accept && i_last_in_frame) begin
            r_frm_valid <= 1'b1;
        end else if (i_take) begin
            r_frm_valid <= 1'b0;
        end
    end

    // Frame summary payload
    always_ff @(posedge i_clk) begin
        if (accept && i_last_in_frame) begin
            r_frm.near_z <= cur_z;
            r_frm.near_x <= cur_x;
            r_frm.vel_in <= i_velocity_in;
            r_frm.ang_in <= i_angular_in;
        end
    end

    assign o_frm_valid = r_frm_valid;
    assign o_frm       = r_frm;

endmodule

`default_nettype wire

@@ rtl/ntf_filter.sv @@
// Lock decision, range smoothing, command forming and result register.
`default_nettype none

module ntf_filter (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire ntf_pkg::t_cfg                      i_cfg,
    input  wire logic                               i_frm_valid,
    input  wire ntf_pkg::t_frame                    i_frm,
    output logic                                    o_take,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed [ntf_pkg::CmdW-1:0]         o_velocity_out,
    output logic signed [ntf_pkg::CmdW-1:0]         o_angular_out,
    output logic                                    o_locked,
    output logic [ntf_pkg::RangeW-1:0]              o_filtered_range,
    output logic signed [ntf_pkg::CmdW-1:0]         o_chosen_x,
    output logic [ntf_pkg::RangeW-1:0]              o_chosen_z
);

    logic [ntf_pkg::RangeW-1:0]      r_smooth;
    logic                            r_out_valid;
    logic signed [ntf_pkg::CmdW-1:0] r_vel;
    logic signed [ntf_pkg::CmdW-1:0] r_ang;
    logic                            r_locked;
    logic [ntf_pkg::RangeW-1:0]      r_filt;
    logic signed [ntf_pkg::CmdW-1:0] r_cx;
    logic [ntf_pkg::RangeW-1:0]      r_cz;

    logic                            locked;
    logic [ntf_pkg::AlphaW-1:0]      alpha;
    logic signed [15:0]              diff;
    logic                            snap;
    logic [ntf_pkg::RangeW-1:0]      base;
    logic signed [15:0]              step;
    logic signed [33:0]              prod;
    logic signed [17:0]              delta;
    logic signed [17:0]              sum;
    logic [ntf_pkg::RangeW-1:0]      n_smooth;
    logic signed [31:0]              hprod;
    logic signed [23:0]              hq;
    logic signed [ntf_pkg::CmdW-1:0] ang_sat;
    logic signed [ntf_pkg::CmdW-1:0] n_vel;
    logic signed [ntf_pkg::CmdW-1:0] n_ang;

    // Result register accepts a new frame when empty or being drained
    assign o_take = i_frm_valid && (!r_out_valid || i_out_ready);

    assign locked = i_frm.near_z < i_cfg.max_range;
    assign alpha  = (i_cfg.alpha > ntf_pkg::ALPHA_ONE) ? ntf_pkg::ALPHA_ONE : i_cfg.alpha;

    // Snap when the new range is more than 1 m away from the smoothed one
    assign diff = $signed({1'b0, i_frm.near_z}) - $signed({1'b0, r_smooth});
    assign snap = (diff > ntf_pkg::SNAP_THRESHOLD) || (diff < -ntf_pkg::SNAP_THRESHOLD);
    assign base = snap ? i_frm.near_z : r_smooth;
    assign step = snap ? 16'sd0 : diff;

    // EMA as base + alpha*(z - base) >> 16, floor of a non-negative total
    assign prod     = $signed({1'b0, alpha}) * step;
    assign delta    = prod[33:16];
    assign sum      = $signed({3'b000, base}) + delta;
    assign n_smooth = sum[14:0];

    // Heading: floor(x * gain / 256), saturated to 16 bits
    assign hprod = i_frm.near_x * i_cfg.heading_gain;
    assign hq    = hprod[31:8];
    always_comb begin
        if (hq > 24'sd32767) begin
            ang_sat = 16'sh7fff;
        end else if (hq < -24'sd32768) begin
            ang_sat = 16'sh8000;
        end else begin
            ang_sat = hq[15:0];
        end
    end

    // Command selection
    always_comb begin
        n_vel = i_frm.vel_in;
        n_ang = i_frm.ang_in;
        if (locked) begin
            n_ang = ang_sat;
            if (n_smooth > i_cfg.min_range) begin
                n_vel = i_cfg.follow_speed;
            end
        end
    end

    // Smoothed range state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= '0;
        end else if (o_take && locked) begin
            r_smooth <= n_smooth;
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_vel    <= n_vel;
            r_ang    <= n_ang;
            r_locked <= locked;
            r_filt   <= locked ? n_smooth : r_smooth;
            r_cx     <= i_frm.near_x;
            r_cz     <= i_frm.near_z;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_velocity_out   = r_vel;
    assign o_angular_out    = r_ang;
    assign o_locked         = r_locked;
    assign o_filtered_range = r_filt;
    assign o_chosen_x       = r_cx;
    assign o_chosen_z       = r_cz;

endmodule

`default_nettype wire

@@ dv/nearest_target_follow_control_test.sv @@
// Self-checking testbench for the nearest target follow controller.
`timescale 1ns / 100ps

module nearest_target_follow_control_test;

    localparam int CLK_HALF     = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 550;
    localparam int DRAIN_CYCLES = 4;

    // Indexes beyond the register list; writes there must have no effect
    localparam logic [ntf_pkg::CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [ntf_pkg::CfgIdxW-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic                            det_valid;
        logic [ntf_pkg::ClassW-1:0]      class_id;
        logic signed [ntf_pkg::CmdW-1:0] x;
        logic [ntf_pkg::RangeW-1:0]      z;
        logic                            last;
        logic signed [ntf_pkg::CmdW-1:0] vel_in;
        logic signed [ntf_pkg::CmdW-1:0] ang_in;
    } t_detection;

    typedef struct packed {
        logic signed [ntf_pkg::CmdW-1:0] vel;
        logic signed [ntf_pkg::CmdW-1:0] ang;
        logic                            locked;
        logic [ntf_pkg::RangeW-1:0]      smoothed;
        logic signed [ntf_pkg::CmdW-1:0] x;
        logic [ntf_pkg::RangeW-1:0]      z;
    } t_drive_cmd;

    // Tracks the running nearest detection and the range filter, and holds
    // the drive commands still owed by the block
    class follow_tracker;
        ntf_pkg::t_cfg                   regs;
        logic [ntf_pkg::RangeW-1:0]      best_z;
        logic signed [ntf_pkg::CmdW-1:0] best_x;
        logic [ntf_pkg::RangeW-1:0]      smoothed;
        t_drive_cmd                      expected_cmds[$];
        int                              mismatches;
        int                              cmds_matched;
        int                              frames_locked;

        function new();
            regs = '{target_class: ntf_pkg::RST_TARGET_CLASS,
                     max_range: ntf_pkg::RST_MAX_RANGE,
                     min_range: ntf_pkg::RST_MIN_RANGE, alpha: ntf_pkg::RST_ALPHA,
                     follow_speed: ntf_pkg::RST_FOLLOW_SPEED,
                     heading_gain: ntf_pkg::RST_HEADING_GAIN};
            best_z        = ntf_pkg::SENTINEL_Z;
            best_x        = '0;
            smoothed      = '0;
            mismatches    = 0;
            cmds_matched  = 0;
            frames_locked = 0;
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        function void write_reg(logic [ntf_pkg::CfgIdxW-1:0] idx,
                                logic [ntf_pkg::CfgDataW-1:0] data);
            case (idx)
                ntf_pkg::REG_TARGET_CLASS: regs.target_class = data[ntf_pkg::ClassW-1:0];
                ntf_pkg::REG_MAX_RANGE:    regs.max_range    = data[ntf_pkg::RangeW-1:0];
                ntf_pkg::REG_MIN_RANGE:    regs.min_range    = data[ntf_pkg::RangeW-1:0];
                ntf_pkg::REG_ALPHA:        regs.alpha        = data;
                ntf_pkg::REG_FOLLOW_SPEED: regs.follow_speed = data[ntf_pkg::CmdW-1:0];
                ntf_pkg::REG_HEADING_GAIN: regs.heading_gain = data[ntf_pkg::CmdW-1:0];
                default: ;
            endcase
        endfunction

        // Accepted item: update nearest, and on frame close work out the command
        function void take_item(t_detection d);
            t_drive_cmd                 cmd;
            logic [ntf_pkg::AlphaW-1:0] a;
            int                         diff;
            logic [63:0]                acc;
            longint                     prod;
            if (d.det_valid && d.class_id == regs.target_class && d.z < best_z) begin
                best_z = d.z;
                best_x = d.x;
            end
            if (!d.last)
                return;
            cmd.vel    = d.vel_in;
            cmd.ang    = d.ang_in;
            cmd.locked = best_z < regs.max_range;
            if (cmd.locked) begin
                frames_locked++;
                a    = (regs.alpha > ntf_pkg::ALPHA_ONE) ? ntf_pkg::ALPHA_ONE : regs.alpha;
                diff = int'(best_z) - int'(smoothed);
                // snap when the new range is more than 1 m off
                if (diff > ntf_pkg::SNAP_THRESHOLD || diff < -ntf_pkg::SNAP_THRESHOLD)
                    smoothed = best_z;
                acc = 64'(a) * 64'(best_z) + 64'(ntf_pkg::ALPHA_ONE - a) * 64'(smoothed);
                smoothed = acc[ntf_pkg::RangeW+15:16];
                if (smoothed > regs.min_range)
                    cmd.vel = regs.follow_speed;
                // floor of x * gain / 256, then clamp to 16 bits
                prod = longint'($signed(best_x)) * longint'($signed(regs.heading_gain));
                prod = prod >>> 8;
                if (prod > 32767)
                    cmd.ang = 16'h7FFF;
                else if (prod < -32768)
                    cmd.ang = 16'h8000;
                else
                    cmd.ang = prod[ntf_pkg::CmdW-1:0];
            end
            cmd.smoothed = smoothed;
            cmd.x        = best_x;
            cmd.z        = best_z;
            expected_cmds.push_back(cmd);
            best_z = ntf_pkg::SENTINEL_Z;
            best_x = '0;
        endfunction

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task match_command(t_drive_cmd got);
            t_drive_cmd want;
            if (expected_cmds.size() == 0) begin
                report("result with nothing expected");
                return;
            end
            want = expected_cmds.pop_front();
            check_field("velocity_out", got.vel, want.vel);
            check_field("angular_out", got.ang, want.ang);
            check_field("locked", got.locked, want.locked);
            check_field("filtered_range", got.smoothed, want.smoothed);
            check_field("chosen_x", got.x, want.x);
            check_field("chosen_z", got.z, want.z);
            cmds_matched++;
        endtask
    endclass

    // Block ports
    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [ntf_pkg::CfgIdxW-1:0]     i_cfg_idx = '0;
    logic [ntf_pkg::CfgDataW-1:0]    i_cfg_data = '0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    logic                            i_detection_valid = 1'b0;
    logic [ntf_pkg::ClassW-1:0]      i_class_id = '0;
    logic signed [ntf_pkg::CmdW-1:0] i_target_x = '0;
    logic [ntf_pkg::RangeW-1:0]      i_target_z = '0;
    logic                            i_last_in_frame = 1'b0;
    logic signed [ntf_pkg::CmdW-1:0] i_velocity_in = '0;
    logic signed [ntf_pkg::CmdW-1:0] i_angular_in = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic signed [ntf_pkg::CmdW-1:0] o_velocity_out;
    logic signed [ntf_pkg::CmdW-1:0] o_angular_out;
    logic                            o_locked;
    logic [ntf_pkg::RangeW-1:0]      o_filtered_range;
    logic signed [ntf_pkg::CmdW-1:0] o_chosen_x;
    logic [ntf_pkg::RangeW-1:0]      o_chosen_z;

    follow_tracker tracker = new();

    int cycles      = 0;
    int stall_tick  = 0;
    int burst_left  = 0;
    int items_sent  = 0;
    int config_sets = 0;

    nearest_target_follow_control dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_detection_valid (i_detection_valid),
        .i_class_id        (i_class_id),
        .i_target_x        (i_target_x),
        .i_target_z        (i_target_z),
        .i_last_in_frame   (i_last_in_frame),
        .i_velocity_in     (i_velocity_in),
        .i_angular_in      (i_angular_in),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_velocity_out    (o_velocity_out),
        .o_angular_out     (o_angular_out),
        .o_locked          (o_locked),
        .o_filtered_range  (o_filtered_range),
        .o_chosen_x        (o_chosen_x),
        .o_chosen_z        (o_chosen_z)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("nearest_target_follow_control_test: errors");
            $finish;
        end
    end

    // Receiver back-pressure: rotates through free, random, heavy and toggling
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        case ((stall_tick / 97) % 4)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= 1'($urandom_range(0, 1));
            2:       i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= ~i_out_ready;
        endcase
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.match_command('{o_velocity_out, o_angular_out, o_locked,
                                    o_filtered_range, o_chosen_x, o_chosen_z});
    end

    function automatic t_detection make_item(logic det, logic [ntf_pkg::ClassW-1:0] cls,
                                              int x, int z, logic last, int vel, int ang);
        t_detection d;
        d.det_valid = det;
        d.class_id  = cls;
        d.x         = x[ntf_pkg::CmdW-1:0];
        d.z         = z[ntf_pkg::RangeW-1:0];
        d.last      = last;
        d.vel_in    = vel[ntf_pkg::CmdW-1:0];
        d.ang_in    = ang[ntf_pkg::CmdW-1:0];
        return d;
    endfunction

    // Present one item and hold it until taken; bursts end in a random gap
    task automatic send_item(input t_detection d);
        int gap;
        i_in_valid        <= 1'b1;
        i_detection_valid <= d.det_valid;
        i_class_id        <= d.class_id;
        i_target_x        <= d.x;
        i_target_z        <= d.z;
        i_last_in_frame   <= d.last;
        i_velocity_in     <= d.vel_in;
        i_angular_in      <= d.ang_in;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        tracker.take_item(d);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
            gap = $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop sending and let every owed command come out
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (tracker.expected_cmds.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_one(input logic [ntf_pkg::CfgIdxW-1:0] idx,
                             input logic [ntf_pkg::CfgDataW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
    endtask

    // Write every register, with junk above each field narrower than the data port and a stray index
    task automatic apply_config(input ntf_pkg::t_cfg c);
        logic [31:0] noise;
        noise = $urandom;
        write_one(noise[31] ? REG_SPARE_HI : REG_SPARE_LO, noise[16:0]);
        write_one(ntf_pkg::REG_TARGET_CLASS, {noise[8:0], c.target_class});
        write_one(ntf_pkg::REG_MAX_RANGE, {noise[10:9], c.max_range});
        write_one(ntf_pkg::REG_MIN_RANGE, {noise[12:11], c.min_range});
        write_one(ntf_pkg::REG_ALPHA, c.alpha);
        write_one(ntf_pkg::REG_FOLLOW_SPEED, {noise[13], c.follow_speed});
        write_one(ntf_pkg::REG_HEADING_GAIN, {noise[14], c.heading_gain});
        i_cfg_we <= 1'b0;
        config_sets++;
    endtask

    function automatic ntf_pkg::t_cfg random_config();
        ntf_pkg::t_cfg c;
        int            g;
        c.target_class = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                                     : 8'($urandom);
        case ($urandom_range(0, 5))
            0:       c.max_range = '0;
            1:       c.max_range = '1;
            2:       c.max_range = ntf_pkg::SENTINEL_Z + 15'd1;
            default: c.max_range = 15'($urandom_range(256, 6000));
        endcase
        case ($urandom_range(0, 4))
            0:       c.min_range = '0;
            1:       c.min_range = '1;
            default: c.min_range = 15'($urandom_range(0, 4000));
        endcase
        case ($urandom_range(0, 6))
            0:       c.alpha = '0;
            1:       c.alpha = ntf_pkg::ALPHA_ONE;
            2:       c.alpha = '1;
            3:       c.alpha = ntf_pkg::ALPHA_ONE + 17'd1;
            default: c.alpha = 17'($urandom_range(1, 65535));
        endcase
        case ($urandom_range(0, 3))
            0:       c.follow_speed = 16'h8000;
            1:       c.follow_speed = 16'h7FFF;
            default: c.follow_speed = 16'($urandom);
        endcase
        g = $urandom_range(0, 1024) - 512;
        case ($urandom_range(0, 4))
            0:       c.heading_gain = 16'h8000;
            1:       c.heading_gain = 16'h7FFF;
            2:       c.heading_gain = 16'($urandom);
            default: c.heading_gain = g[ntf_pkg::CmdW-1:0];
        endcase
        return c;
    endfunction

    // Mostly detections of the followed class at ranges up to a little past the lock threshold
    function automatic t_detection pick_detection(input logic last);
        t_detection d;
        int         span;
        int         t;
        int         xs;
        d.det_valid = 1'b1;
        d.class_id  = tracker.regs.target_class;
        d.x         = 16'($urandom);
        d.z         = '0;
        d.last      = last;
        d.vel_in    = 16'($urandom);
        d.ang_in    = 16'($urandom);
        span = int'(tracker.regs.max_range) + 400;
        if (span > 32767) span = 32767;
        if (span < 600)   span = 600;
        case ($urandom_range(0, 9))
            0: begin
                d.det_valid = 1'b0;
                d.class_id  = 8'($urandom);
                d.z         = 15'($urandom);
            end
            1: begin
                d.class_id = 8'($urandom);
                d.z        = 15'($urandom_range(0, span));
            end
            2: begin
                case ($urandom_range(0, 3))
                    0:       d.z = '0;
                    1:       d.z = ntf_pkg::SENTINEL_Z;
                    2:       d.z = '1;
                    default: d.z = 15'($urandom);
                endcase
            end
            3: begin
                // hover around the snap band of the filter
                t = int'(tracker.smoothed) + int'($urandom_range(0, 600)) - 300;
                if (t < 0)     t = 0;
                if (t > 32767) t = 32767;
                d.z = t[ntf_pkg::RangeW-1:0];
            end
            default: d.z = 15'($urandom_range(0, span));
        endcase
        if ($urandom_range(0, 3) == 0) begin
            xs  = int'($urandom_range(0, 1024)) - 512;
            d.x = xs[ntf_pkg::CmdW-1:0];
        end
        return d;
    endfunction

    task automatic send_frame();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
            send_item(pick_detection(i == n - 1));
    endtask

    // Main sequence
    initial begin
        ntf_pkg::t_cfg c;
        int            stop_at;
        int            phase_end;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: empty frame, nearest at zero, lock threshold edge
        send_item(make_item(0, 8'd0, 0, 0, 1, 32767, -32768));
        send_item(make_item(1, 8'd0, 32767, 0, 0, 0, 0));
        send_item(make_item(0, 8'd255, -1, 32767, 1, -32768, 32767));
        send_item(make_item(1, 8'd0, 100, 25600, 0, 5, 5));     // sentinel range never taken
        send_item(make_item(1, 8'd5, -100, 10, 0, 5, 5));       // other class
        send_item(make_item(0, 8'd0, 7, 5, 0, 5, 5));           // empty marker mid-frame
        send_item(make_item(1, 8'd0, -32768, 1279, 1, 1234, -1234));
        send_item(make_item(1, 8'd0, 5, 1280, 1, 77, -77));     // equal to max: no lock
        send_item(make_item(1, 8'd255, -5, 32767, 1, -9, 9));

        // Wide open lock, alpha above one, extreme speed and gain
        wait_idle();
        c = '{target_class: 8'hFF, max_range: 15'h7FFF, min_range: 15'h0000,
              alpha: 17'h1FFFF, follow_speed: 16'h8000, heading_gain: 16'h8000};
        apply_config(c);
        send_item(make_item(0, 8'd0, 0, 0, 1, 11, 22));         // empty frame locks on sentinel
        send_item(make_item(1, 8'd255, -32768, 300, 1, 0, 0));
        send_item(make_item(1, 8'd255, 32767, 400, 1, 0, 0));
        send_item(make_item(1, 8'd255, -1, 0, 1, 0, 0));

        // Frozen filter: snap band edges on both sides
        wait_idle();
        c = '{target_class: 8'h5A, max_range: ntf_pkg::SENTINEL_Z + 15'd1,
              min_range: 15'h7FFF, alpha: 17'h00000, follow_speed: 16'h7FFF,
              heading_gain: 16'h0001};
        apply_config(c);
        send_item(make_item(1, 8'h5A, -1, 1000, 1, 3, 4));
        send_item(make_item(1, 8'h5A, 3, 1200, 1, 3, 4));
        send_item(make_item(1, 8'h5A, -3, 800, 1, 3, 4));
        send_item(make_item(1, 8'h5A, 9, 1257, 1, 3, 4));
        send_item(make_item(1, 8'h5A, 9, 1001, 1, 3, 4));
        send_item(make_item(1, 8'h5A, 9, 25600, 1, 3, 4));

        // Random phases, each under fresh settings
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            wait_idle();
            apply_config(random_config());
            phase_end = items_sent + $urandom_range(50, 80);
            while (items_sent < phase_end) begin
                send_frame();
                if ($urandom_range(0, 19) == 0)
                    wait_idle();
            end
        end

        wait_idle();
        $display("%0d items sent, %0d commands checked (%0d locked), %0d register settings",
                 items_sent, tracker.cmds_matched, tracker.frames_locked, config_sets);
        if (tracker.mismatches == 0) begin
            $display("nearest_target_follow_control_test: clean");
        end else begin
            $display("%0d mismatches", tracker.mismatches);
            $display("nearest_target_follow_control_test: errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ntf_pkg.sv
rtl/ntf_cfg.sv
rtl/ntf_track.sv
rtl/ntf_filter.sv
rtl/nearest_target_follow_control.sv
dv/nearest_target_follow_control_test.sv
